// File: hw/rtl/slpr_pkg.sv
// Shared types and constants for the second-order low-pass filter with rate output.
package slpr_pkg;

    localparam int COEF_W     = 40;
    localparam int VEL_W      = 32;
    localparam int SR_W       = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_POS_RATE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_POS_ERR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_RATE_RATE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_RATE_ERR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE_HZ = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BYPASS         = 3'd5;

    localparam logic [SR_W-1:0] SAMPLE_RATE_RESET = 16'd1000;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_pos_rate;
        logic signed [COEF_W-1:0] coef_pos_err;
        logic signed [COEF_W-1:0] coef_rate_rate;
        logic signed [COEF_W-1:0] coef_rate_err;
        logic        [SR_W-1:0]   sample_rate_hz;
        logic                     bypass;
    } t_cfg;

endpackage

// File: hw/rtl/slpr_in_if.sv
// Sample channel: valid/ready handshake carrying one sample and a restart flag.
interface slpr_in_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           restart;

    modport source (output valid, output sample, output restart, input ready);
    modport sink   (input valid, input sample, input restart, output ready);
endinterface

// File: hw/rtl/slpr_out_if.sv
// Result channel: valid/ready handshake carrying the filtered value and its rate.
interface slpr_out_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] filtered;
    logic signed [31:0]             rate;

    modport source (output valid, output filtered, output rate, input ready);
    modport sink   (input valid, input filtered, input rate, output ready);
endinterface

// File: hw/rtl/slpr_cfg.sv
// Configuration register bank for the filter coefficients, sample rate and bypass.
module slpr_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [slpr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [slpr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output slpr_pkg::t_cfg                      o_cfg
);

    slpr_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coef_pos_rate  <= '0;
            r_cfg.coef_pos_err   <= '0;
            r_cfg.coef_rate_rate <= '0;
            r_cfg.coef_rate_err  <= '0;
            r_cfg.sample_rate_hz <= slpr_pkg::SAMPLE_RATE_RESET;
            r_cfg.bypass         <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                slpr_pkg::REG_COEF_POS_RATE: begin
                    r_cfg.coef_pos_rate <= i_cfg_data[slpr_pkg::COEF_W-1:0];
                end
                slpr_pkg::REG_COEF_POS_ERR: begin
                    r_cfg.coef_pos_err <= i_cfg_data[slpr_pkg::COEF_W-1:0];
                end
                slpr_pkg::REG_COEF_RATE_RATE: begin
                    r_cfg.coef_rate_rate <= i_cfg_data[slpr_pkg::COEF_W-1:0];
                end
                slpr_pkg::REG_COEF_RATE_ERR: begin
                    r_cfg.coef_rate_err <= i_cfg_data[slpr_pkg::COEF_W-1:0];
                end
                slpr_pkg::REG_SAMPLE_RATE_HZ: begin
                    r_cfg.sample_rate_hz <= i_cfg_data[slpr_pkg::SR_W-1:0];
                end
                slpr_pkg::REG_BYPASS: begin
                    r_cfg.bypass <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hw/rtl/slpr_calc.sv
// Next-state logic: load, bypass differentiation or state-space filter update.
module slpr_calc #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int COEF_FRAC_BITS = 24
) (
    input  slpr_pkg::t_cfg                      i_cfg,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_sample,
    input  logic                                i_restart,
    input  logic                                i_init,
    input  logic signed [SAMPLE_WIDTH+7:0]      i_pos,
    input  logic signed [slpr_pkg::VEL_W-1:0]   i_vel,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_prev,
    output logic signed [SAMPLE_WIDTH+7:0]      o_pos,
    output logic signed [slpr_pkg::VEL_W-1:0]   o_vel,
    output logic signed [SAMPLE_WIDTH-1:0]      o_filtered
);

    localparam int POS_W  = SAMPLE_WIDTH + 8;
    localparam int ERR_W  = SAMPLE_WIDTH + 9;
    localparam int VEL_W  = slpr_pkg::VEL_W;
    localparam int COEF_W = slpr_pkg::COEF_W;
    localparam int ACC_W  = COEF_W + ((VEL_W > ERR_W) ? VEL_W : ERR_W) + 2;
    localparam int DIF_W  = SAMPLE_WIDTH + 1;
    localparam int BYP_W  = DIF_W + slpr_pkg::SR_W + 9;
    localparam int RND_W  = POS_W + 1;

    localparam logic signed [ACC_W-1:0] RND     = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] POS_MAX = (ACC_W'(1) <<< (POS_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] POS_MIN = -POS_MAX - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] VEL_MAX = (ACC_W'(1) <<< (VEL_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] VEL_MIN = -VEL_MAX - ACC_W'(1);
    localparam logic signed [BYP_W-1:0] BVEL_MAX = (BYP_W'(1) <<< (VEL_W - 1)) - BYP_W'(1);
    localparam logic signed [BYP_W-1:0] BVEL_MIN = -BVEL_MAX - BYP_W'(1);
    localparam logic signed [RND_W-1:0] FLT_MAX =
        (RND_W'(1) <<< (SAMPLE_WIDTH - 1)) - RND_W'(1);
    localparam logic signed [RND_W-1:0] FLT_MIN = -FLT_MAX - RND_W'(1);

    logic signed [ERR_W-1:0] in_sum;
    logic signed [ERR_W-1:0] err;
    logic signed [ACC_W-1:0] p_pr, p_pe, p_rr, p_re;
    logic signed [ACC_W-1:0] t_pr, t_pe, t_rr, t_re;
    logic signed [ACC_W-1:0] np, nv;
    logic signed [POS_W-1:0] np_sat;
    logic signed [VEL_W-1:0] nv_sat;
    logic signed [DIF_W-1:0] diff;
    logic signed [BYP_W-1:0] byp;
    logic signed [VEL_W-1:0] byp_sat;
    logic signed [POS_W-1:0] load_pos;
    logic signed [RND_W-1:0] pos_rnd;
    logic signed [RND_W-1:0] pos_int;

    assign in_sum = ERR_W'(i_sample) + ERR_W'(i_prev);
    assign err    = (in_sum <<< 7) - ERR_W'(i_pos);

    assign p_pr = ACC_W'(i_cfg.coef_pos_rate)  * ACC_W'(i_vel);
    assign p_pe = ACC_W'(i_cfg.coef_pos_err)   * ACC_W'(err);
    assign p_rr = ACC_W'(i_cfg.coef_rate_rate) * ACC_W'(i_vel);
    assign p_re = ACC_W'(i_cfg.coef_rate_err)  * ACC_W'(err);

    assign t_pr = (p_pr + RND) >>> COEF_FRAC_BITS;
    assign t_pe = (p_pe + RND) >>> COEF_FRAC_BITS;
    assign t_rr = (p_rr + RND) >>> COEF_FRAC_BITS;
    assign t_re = (p_re + RND) >>> COEF_FRAC_BITS;

    assign np = ACC_W'(i_pos) + t_pr + t_pe;
    assign nv = t_rr + t_re;

    assign np_sat = (np > POS_MAX) ? POS_MAX[POS_W-1:0] :
                    (np < POS_MIN) ? POS_MIN[POS_W-1:0] : np[POS_W-1:0];
    assign nv_sat = (nv > VEL_MAX) ? VEL_MAX[VEL_W-1:0] :
                    (nv < VEL_MIN) ? VEL_MIN[VEL_W-1:0] : nv[VEL_W-1:0];

    assign diff = DIF_W'(i_sample) - DIF_W'(i_prev);
    assign byp  = (BYP_W'(diff) * $signed(BYP_W'(i_cfg.sample_rate_hz))) <<< 8;
    assign byp_sat = (byp > BVEL_MAX) ? BVEL_MAX[VEL_W-1:0] :
                     (byp < BVEL_MIN) ? BVEL_MIN[VEL_W-1:0] : byp[VEL_W-1:0];

    assign load_pos = POS_W'(i_sample) <<< 8;

    always_comb begin
        if (i_init || i_restart) begin
            o_pos = load_pos;
            o_vel = '0;
        end else if (i_cfg.bypass) begin
            o_pos = load_pos;
            o_vel = byp_sat;
        end else begin
            o_pos = np_sat;
            o_vel = nv_sat;
        end
    end

    assign pos_rnd = RND_W'(o_pos) + RND_W'(128);
    assign pos_int = pos_rnd >>> 8;
    assign o_filtered = (pos_int > FLT_MAX) ? FLT_MAX[SAMPLE_WIDTH-1:0] :
                        (pos_int < FLT_MIN) ? FLT_MIN[SAMPLE_WIDTH-1:0] :
                        pos_int[SAMPLE_WIDTH-1:0];

endmodule

// File: hw/rtl/second_order_lowpass_with_rate.sv
// Second-order state-space low-pass filter with rate output, top level.
// Path: input register, then result register; a sample advances into the result register
// only while the result register is empty or its result is being taken.
// Throughput: one transaction per cycle while results are taken; the state loop closes in the single update stage.
// Reset (synchronous, active low): pipeline empty, state zero, next sample loads the state,
// coefficients zero, sample rate 1000 Hz, bypass off.
module second_order_lowpass_with_rate #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int COEF_FRAC_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    slpr_in_if.sink                             i_smp,
    slpr_out_if.source                          o_res,
    input  logic                                i_cfg_we,
    input  logic [slpr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [slpr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int POS_W = SAMPLE_WIDTH + 8;
    localparam int VEL_W = slpr_pkg::VEL_W;

    slpr_pkg::t_cfg cfg;

    logic                           r_in_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_in_sample;
    logic                           r_in_restart;

    logic signed [POS_W-1:0]        r_pos;
    logic signed [VEL_W-1:0]        r_vel;
    logic signed [SAMPLE_WIDTH-1:0] r_prev;
    logic                           r_init;

    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_filt;
    logic signed [VEL_W-1:0]        r_out_rate;

    logic signed [POS_W-1:0]        n_pos;
    logic signed [VEL_W-1:0]        n_vel;
    logic signed [SAMPLE_WIDTH-1:0] n_filt;

    logic advance;
    logic in_take;

    slpr_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    slpr_calc #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_calc (
        .i_cfg      (cfg),
        .i_sample   (r_in_sample),
        .i_restart  (r_in_restart),
        .i_init     (r_init),
        .i_pos      (r_pos),
        .i_vel      (r_vel),
        .i_prev     (r_prev),
        .o_pos      (n_pos),
        .o_vel      (n_vel),
        .o_filtered (n_filt)
    );

    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_smp.ready = !r_in_valid || advance;
    assign in_take     = i_smp.valid && i_smp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_smp.ready) begin
            r_in_valid <= i_smp.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_sample  <= i_smp.sample;
            r_in_restart <= i_smp.restart;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_vel  <= '0;
            r_prev <= '0;
            r_init <= 1'b1;
        end else if (advance) begin
            r_pos  <= n_pos;
            r_vel  <= n_vel;
            r_prev <= r_in_sample;
            r_init <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_filt <= n_filt;
            r_out_rate <= n_vel;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.filtered = r_out_filt;
    assign o_res.rate     = r_out_rate;

    // a load transaction always reports zero rate
    a_load_zero_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_init || r_in_restart)) |=> (r_out_rate == '0))
        else $error("load transaction produced nonzero rate");

    a_init_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> !r_init)
        else $error("init flag still set after first transaction");

    // a held input transaction is not overwritten
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_sample)))
        else $error("pending input transaction lost");

    a_result_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_out_valid && (r_out_rate == r_vel)))
        else $error("result rate does not match velocity state");

endmodule
